// ===== src/pl0_pkg.sv =====
// Shared opcodes, fault codes and controller/datapath command types.
package pl0_pkg;
  localparam logic [4:0] OP_LIT = 5'd1;
  localparam logic [4:0] OP_RTN = 5'd2;
  localparam logic [4:0] OP_LOD = 5'd3;
  localparam logic [4:0] OP_STO = 5'd4;
  localparam logic [4:0] OP_CAL = 5'd5;
  localparam logic [4:0] OP_INC = 5'd6;
  localparam logic [4:0] OP_JMP = 5'd7;
  localparam logic [4:0] OP_JPC = 5'd8;
  localparam logic [4:0] OP_SIO = 5'd9;
  localparam logic [4:0] OP_NEG = 5'd10;
  localparam logic [4:0] OP_ADD = 5'd11;
  localparam logic [4:0] OP_SUB = 5'd12;
  localparam logic [4:0] OP_MUL = 5'd13;
  localparam logic [4:0] OP_DIV = 5'd14;
  localparam logic [4:0] OP_ODD = 5'd15;
  localparam logic [4:0] OP_MOD = 5'd16;
  localparam logic [4:0] OP_EQL = 5'd17;
  localparam logic [4:0] OP_NEQ = 5'd18;
  localparam logic [4:0] OP_LSS = 5'd19;
  localparam logic [4:0] OP_LEQ = 5'd20;
  localparam logic [4:0] OP_GTR = 5'd21;
  localparam logic [4:0] OP_GEQ = 5'd22;

  localparam logic [2:0] FLT_OK    = 3'd0;
  localparam logic [2:0] FLT_OP    = 3'd1;
  localparam logic [2:0] FLT_CAL   = 3'd2;
  localparam logic [2:0] FLT_DIV0  = 3'd3;
  localparam logic [2:0] FLT_RANGE = 3'd4;

  localparam logic [31:0] SIO_WRITE = 32'd1;
  localparam logic [31:0] SIO_READ  = 32'd2;
  localparam logic [31:0] SIO_HALT  = 32'd3;

  // Datapath commands, one per controller state.
  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_LATCH  = 4'd1;  // take the beat, read regs
  localparam logic [3:0] CMD_DECIDE = 4'd2;  // ops finished here, set up memory read
  localparam logic [3:0] CMD_LINK   = 4'd3;  // consume one static link word
  localparam logic [3:0] CMD_LDST   = 4'd4;  // address check, issue load/store
  localparam logic [3:0] CMD_LDWB   = 4'd5;  // write loaded word
  localparam logic [3:0] CMD_RTN1   = 4'd6;  // got saved base, read return addr
  localparam logic [3:0] CMD_RTN2   = 4'd7;  // got return address, commit
  localparam logic [3:0] CMD_DIVST  = 4'd8;  // one quotient bit
  localparam logic [3:0] CMD_DIVWB  = 4'd9;  // write quotient or remainder
  localparam logic [3:0] CMD_MULWB  = 4'd10; // write registered product

  typedef struct packed {
    logic [3:0] cmd;
  } pl0_ctl_t;

  typedef struct packed {
    logic       clearing;  // stack memory clearing pass still running
    logic       done;      // result is final this cycle
    logic       walk_more; // another link to follow
    logic       go_link;
    logic       go_ldst;
    logic       go_rtn;
    logic       go_div;
    logic       go_mul;
    logic       div_last;
  } pl0_sts_t;
endpackage

// ===== src/pl0_datapath.sv =====
// Datapath: register file, stack memory, pointers, ALU and serial divider.
module pl0_datapath #(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 512,
  parameter int NUM_REGS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pl0_pkg::pl0_ctl_t   ctl,
  output pl0_pkg::pl0_sts_t   sts,
  input  logic [4:0]          func,
  input  logic [3:0]          reg_sel,
  input  logic [3:0]          level_or_src_a,
  input  logic signed [31:0]  operand_m,
  input  logic signed [31:0]  read_value,
  output logic [8:0]          next_pc,
  output logic [9:0]          frame_base_out,
  output logic [9:0]          stack_top_out,
  output logic                print_valid,
  output logic signed [31:0]  print_value,
  output logic                halted,
  output logic [2:0]          fault
);
  import pl0_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CAW = $clog2(CODE_DEPTH);
  localparam int RAW = $clog2(NUM_REGS);

  logic [31:0] regs [NUM_REGS];
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata;
  logic           clr_busy;
  logic [SAW-1:0] clr_addr;

  logic [CAW-1:0] pc;
  logic [SAW-1:0] bp, sp;
  logic           halt;

  // latched instruction
  logic [4:0]  op;
  logic [3:0]  r;
  logic [31:0] m, rd;
  logic [31:0] va, vb, vr;
  logic        r_ok, la_ok, m_ok;
  logic [3:0]  levels;
  logic [SAW-1:0] base;

  // divider
  logic [31:0] dq, drem, dden, ddiv;
  logic        dneg_q, dneg_r;
  logic [4:0]  dcnt;
  logic [31:0] prod;

  logic [31:0] memq;
  assign memq = rdata;

  function automatic logic [31:0] rget(input logic [3:0] i);
    logic [31:0] x;
    x = 32'd0;
    if (32'(i) < NUM_REGS) x = regs[i[RAW-1:0]];
    return x;
  endfunction

  // memory port requests
  logic           mrd, mwr;
  logic [SAW-1:0] maddr;
  logic [31:0]    mwdata;

  // register write request
  logic           rwr;
  logic [3:0]     rwa;
  logic [31:0]    rwd;

  // Zero the stack memory one word per cycle after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + SAW'(1);
      if (32'(clr_addr) == STACK_DEPTH - 1) clr_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) mem[clr_addr] <= '0;
    else if (mwr) mem[maddr] <= mwdata;
    if (mrd) rdata <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (rwr) begin
      regs[rwa[RAW-1:0]] <= rwd;
    end
  end

  // sign-extended helpers
  logic signed [33:0] link_s, addr_s, nsp_s;
  logic signed [31:0] sa, sb;
  assign sa = va;
  assign sb = vb;

  function automatic logic sok(input logic signed [33:0] a);
    return a >= 0 && a < 34'(STACK_DEPTH);
  endfunction
  function automatic logic cok(input logic signed [33:0] a);
    return a >= 0 && a < 34'(CODE_DEPTH);
  endfunction

  logic [CAW-1:0] pc_inc;
  assign pc_inc = (32'(pc) == CODE_DEPTH - 1) ? '0 : pc + CAW'(1);

  logic [2:0] flt;
  logic       pv;
  logic [31:0] pval;
  logic [SAW-1:0] save_bp;
  logic [31:0] rdata_keep;

  // results computed directly for CMD_DECIDE
  logic        wr_single;
  logic [31:0] wd_single;
  logic [2:0]  flt_single;

  always_comb begin
    sts    = '0;
    sts.clearing = clr_busy;
    mrd = 1'b0; mwr = 1'b0; maddr = '0; mwdata = '0;
    rwr = 1'b0; rwa = r; rwd = '0;
    link_s = 34'(signed'(memq));
    addr_s = $signed({{(34-SAW){1'b0}}, base}) + 34'(signed'(m));
    nsp_s  = $signed({{(34-SAW){1'b0}}, bp}) - 34'sd1;
    case (ctl.cmd)
      CMD_DECIDE: begin
        // a halted machine ignores the instruction entirely
        if (!halt) begin
          case (op)
            OP_LOD, OP_STO: if (r_ok) begin
              if (levels != 4'd0) begin
                sts.go_link = 1'b1;
                maddr = SAW'((34'(base) + 34'd1));
                mrd = sok(34'(base) + 34'sd1);
              end else sts.go_ldst = 1'b1;
            end
            OP_RTN: begin
              if (sok(nsp_s) && sok(nsp_s + 34'sd4)) begin
                sts.go_rtn = 1'b1;
                mrd = 1'b1;
                maddr = SAW'(nsp_s + 34'sd3);
              end
            end
            OP_MUL: sts.go_mul = r_ok && la_ok && m_ok;
            OP_DIV, OP_MOD: sts.go_div = r_ok && la_ok && m_ok && vb != 0;
            default: ;
          endcase
          if (op == OP_SIO && m == SIO_READ) begin
            mwr = 1'b1; maddr = sp; mwdata = rd;
          end
          rwr = wr_single;
          rwd = wd_single;
        end
        sts.done = !(sts.go_link || sts.go_ldst || sts.go_rtn || sts.go_mul
                     || sts.go_div);
      end
      CMD_LINK: begin
        // memq holds stack[base+1] if address was fine; a bad link ends the walk
        sts.done = !(sok(34'(base) + 34'sd1) && sok(link_s));
        sts.walk_more = !sts.done && levels > 4'd1;
        if (sts.walk_more) begin
          maddr = SAW'(link_s + 34'sd1);
          mrd = sok(link_s + 34'sd1);
        end
      end
      CMD_LDST: begin
        maddr = SAW'(addr_s);
        if (sok(addr_s)) begin
          if (op == OP_LOD) mrd = 1'b1;
          else begin mwr = 1'b1; mwdata = vr; end
        end
        sts.done = !(op == OP_LOD && sok(addr_s));
      end
      CMD_LDWB: begin
        rwr = 1'b1; rwd = memq; sts.done = 1'b1;
      end
      CMD_RTN1: begin
        mrd = 1'b1; maddr = SAW'(nsp_s + 34'sd4);
      end
      CMD_RTN2: sts.done = 1'b1;
      CMD_DIVST: sts.div_last = dcnt == 5'd0;
      CMD_DIVWB: begin
        rwr = 1'b1;
        rwd = (op == OP_DIV) ? (dneg_q ? 32'd0 - dq : dq)
                             : (dneg_r ? 32'd0 - drem : drem);
        sts.done = 1'b1;
      end
      CMD_MULWB: begin
        rwr = 1'b1; rwd = prod; sts.done = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_single = 1'b0; wd_single = '0; flt_single = FLT_OK;
    if (op >= OP_NEG) begin
      if (!r_ok) flt_single = FLT_OP;
      else if (op == OP_NEG) begin wr_single = 1'b1; wd_single = 32'd0 - vr; end
      else if (op == OP_ODD) begin wr_single = 1'b1; wd_single = {31'd0, vr[0]}; end
      else if (!la_ok || !m_ok) flt_single = FLT_OP;
      else begin
        wr_single = 1'b1;
        case (op)
          OP_ADD: wd_single = va + vb;
          OP_SUB: wd_single = va - vb;
          OP_EQL: wd_single = {31'd0, sa == sb};
          OP_NEQ: wd_single = {31'd0, sa != sb};
          OP_LSS: wd_single = {31'd0, sa < sb};
          OP_LEQ: wd_single = {31'd0, sa <= sb};
          OP_GTR: wd_single = {31'd0, sa > sb};
          OP_GEQ: wd_single = {31'd0, sa >= sb};
          OP_MUL: wr_single = 1'b0;
          OP_DIV, OP_MOD: begin
            wr_single = 1'b0;
            if (vb == 0) flt_single = FLT_DIV0;
          end
          default: begin wr_single = 1'b0; flt_single = FLT_OP; end
        endcase
      end
    end else begin
      case (op)
        OP_LIT: begin
          if (!r_ok) flt_single = FLT_OP;
          else begin wr_single = 1'b1; wd_single = m; end
        end
        OP_LOD, OP_STO: if (!r_ok) flt_single = FLT_OP;
        OP_RTN: if (!(sok(nsp_s) && sok(nsp_s + 34'sd4))) flt_single = FLT_RANGE;
        OP_CAL: flt_single = FLT_CAL;
        OP_INC: if (!sok($signed({{(34-SAW){1'b0}}, sp}) + 34'(signed'(m))))
                  flt_single = FLT_RANGE;
        OP_JMP: if (!cok(34'(signed'(m)))) flt_single = FLT_RANGE;
        OP_JPC: begin
          if (!r_ok) flt_single = FLT_OP;
          else if (vr == 0 && !cok(34'(signed'(m)))) flt_single = FLT_RANGE;
        end
        OP_SIO: begin
          if (m == SIO_WRITE) begin
            if (!r_ok) flt_single = FLT_OP;
          end else if (m != SIO_READ && m != SIO_HALT) flt_single = FLT_OP;
        end
        default: flt_single = FLT_OP;
      endcase
    end
  end

  logic signed [33:0] inc_s;
  assign inc_s = $signed({{(34-SAW){1'b0}}, sp}) + 34'(signed'(m));

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0; bp <= SAW'(1); sp <= '0; halt <= 1'b0;
      flt <= FLT_OK; pv <= 1'b0; pval <= '0;
    end else begin
      case (ctl.cmd)
        CMD_LATCH: begin
          op <= func; r <= reg_sel; m <= operand_m;
          rd <= read_value; levels <= level_or_src_a; base <= bp;
          r_ok  <= 32'(reg_sel) < NUM_REGS;
          la_ok <= 32'(level_or_src_a) < NUM_REGS;
          m_ok  <= !operand_m[31] && operand_m < NUM_REGS;
          vr <= rget(reg_sel);
          va <= rget(level_or_src_a);
          vb <= (!operand_m[31] && operand_m < NUM_REGS) ? rget(operand_m[3:0]) : '0;
          pv <= 1'b0; pval <= '0; flt <= FLT_OK;
        end
        CMD_DECIDE: if (!halt) begin
          pc  <= pc_inc;
          flt <= flt_single;
          if (flt_single == FLT_OK) begin
            case (op)
              OP_INC: sp <= SAW'(inc_s);
              OP_JMP: pc <= CAW'(m);
              OP_JPC: if (vr == 0) pc <= CAW'(m);
              OP_SIO: begin
                if (m == SIO_WRITE) begin pv <= 1'b1; pval <= vr; end
                if (m == SIO_HALT) halt <= 1'b1;
              end
              default: ;
            endcase
          end
          prod <= va * vb;
          dneg_q <= va[31] ^ vb[31];
          dneg_r <= va[31];
          dden <= va[31] ? 32'd0 - va : va;
          ddiv <= vb[31] ? 32'd0 - vb : vb;
          dq <= '0; drem <= '0; dcnt <= 5'd31;
        end
        CMD_LINK: begin
          if (!sok(34'(base) + 34'sd1) || !sok(link_s)) flt <= FLT_RANGE;
          else begin
            base <= SAW'(link_s);
            levels <= levels - 4'd1;
          end
        end
        CMD_LDST: if (!sok(addr_s)) flt <= FLT_RANGE;
        CMD_RTN1: save_bp <= SAW'(link_s);
        CMD_RTN2: begin
          if (!sok(34'(signed'(rdata_keep))) || !cok(link_s)) flt <= FLT_RANGE;
          else begin
            sp <= SAW'(nsp_s); bp <= save_bp; pc <= CAW'(link_s);
          end
        end
        CMD_DIVST: begin
          {drem, dden} <= ({drem, dden} << 1) >= {ddiv, 32'd0}
                          ? (({drem, dden} << 1) - {ddiv, 32'd0}) : ({drem, dden} << 1);
          dq <= {dq[30:0], (({drem, dden} << 1) >= {ddiv, 32'd0})};
          dcnt <= dcnt - 5'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) if (ctl.cmd == CMD_RTN1) rdata_keep <= memq;

  assign next_pc        = 9'(pc);
  assign frame_base_out = 10'(bp);
  assign stack_top_out  = 10'(sp);
  assign print_valid    = pv;
  assign print_value    = pval;
  assign halted         = halt;
  assign fault          = flt;
endmodule

// ===== src/pl0_ctrl.sv =====
// Controller: sequences one instruction through the datapath and runs the stream handshake.
module pl0_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pl0_pkg::pl0_ctl_t ctl,
  input  pl0_pkg::pl0_sts_t sts
);
  import pl0_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_LINK = 4'd2;
  localparam logic [3:0] S_LDST = 4'd3;
  localparam logic [3:0] S_LDWB = 4'd4;
  localparam logic [3:0] S_RTN1 = 4'd5;
  localparam logic [3:0] S_RTN2 = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DWB  = 4'd8;
  localparam logic [3:0] S_MWB  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state, state_next;

  assign in_ready  = state == S_IDLE && !sts.clearing;
  assign out_valid = state == S_OUT;

  always_comb begin
    ctl.cmd = CMD_NONE;
    state_next = state;
    case (state)
      S_IDLE: if (in_valid && !sts.clearing) begin
        ctl.cmd = CMD_LATCH; state_next = S_DEC;
      end
      S_DEC: begin
        ctl.cmd = CMD_DECIDE;
        if (sts.go_link) state_next = S_LINK;
        else if (sts.go_ldst) state_next = S_LDST;
        else if (sts.go_rtn) state_next = S_RTN1;
        else if (sts.go_div) state_next = S_DIV;
        else if (sts.go_mul) state_next = S_MWB;
        else state_next = S_OUT;
      end
      S_LINK: begin
        ctl.cmd = CMD_LINK;
        if (sts.done) state_next = S_OUT;
        else state_next = sts.walk_more ? S_LINK : S_LDST;
      end
      S_LDST: begin ctl.cmd = CMD_LDST; state_next = sts.done ? S_OUT : S_LDWB; end
      S_LDWB: begin ctl.cmd = CMD_LDWB; state_next = S_OUT; end
      S_RTN1: begin ctl.cmd = CMD_RTN1; state_next = S_RTN2; end
      S_RTN2: begin ctl.cmd = CMD_RTN2; state_next = S_OUT; end
      S_DIV:  begin ctl.cmd = CMD_DIVST; if (sts.div_last) state_next = S_DWB; end
      S_DWB:  begin ctl.cmd = CMD_DIVWB; state_next = S_OUT; end
      S_MWB:  begin ctl.cmd = CMD_MULWB; state_next = S_OUT; end
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ===== src/pl0_register_machine_execute_core.sv =====
// Top level of the PL/0 register machine execution unit.
// One beat in carries one instruction; one beat out reports the machine state after it.
// After reset the stack memory is zeroed one word per cycle, and the first beat is taken
// only once that clearing pass ends. Each instruction is taken, decided and presented,
// and the result is held until m_tready. Multiply adds a write of the registered product,
// store adds the address check and store, load and return add steps around the stack
// memory read port (registered data), each static link level walked adds a link step (a
// bad link ends the walk at once), and divide/modulo runs the serial divider (one quotient
// bit per cycle) before writing back. One instruction is in flight at a time.
module pl0_register_machine_execute_core #(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 512,
  parameter int NUM_REGS    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func[4:0], reg_sel[8:5], level_or_src_a[12:9], operand_m[44:13],
  // read_value[76:45], zero fill to 80
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_pc[8:0], frame_base_out[18:9], stack_top_out[28:19], print_valid[29],
  // print_value[61:30], halted[62], fault[65:63], zero fill to 72
  output logic [71:0]  m_tdata
);
  import pl0_pkg::*;

  pl0_ctl_t ctl;
  pl0_sts_t sts;
  logic [8:0] npc;
  logic [9:0] fb, st;
  logic pv, hl;
  logic [31:0] pval;
  logic [2:0] flt;

  pl0_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .ctl(ctl), .sts(sts)
  );

  pl0_datapath #(
    .STACK_DEPTH(STACK_DEPTH), .CODE_DEPTH(CODE_DEPTH), .NUM_REGS(NUM_REGS)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .func(s_tdata[4:0]), .reg_sel(s_tdata[8:5]), .level_or_src_a(s_tdata[12:9]),
    .operand_m(s_tdata[44:13]), .read_value(s_tdata[76:45]),
    .next_pc(npc), .frame_base_out(fb), .stack_top_out(st), .print_valid(pv),
    .print_value(pval), .halted(hl), .fault(flt)
  );

  assign m_tdata = {6'd0, flt, hl, pval, pv, st, fb, npc};
endmodule

// ===== dv/tb_pl0_register_machine_execute_core.sv =====
// Self-checking testbench for the PL/0 register machine execution unit.
`timescale 1ns / 100ps

module tb_pl0_register_machine_execute_core;
  import pl0_pkg::*;

  localparam int STK_WORDS  = 1024;
  localparam int CODE_WORDS = 512;
  localparam int REG_COUNT  = 16;
  localparam int RAND_ITEMS = 1920;

  // Machine state as reported by one output beat, highest field first.
  typedef struct packed {
    logic [2:0]  fault;
    logic        halted;
    logic [31:0] print_value;
    logic        print_valid;
    logic [9:0]  stack_top;
    logic [9:0]  frame_base;
    logic [8:0]  next_pc;
  } exec_report_t;

  // Shadow machine: executes each accepted instruction and queues the state report.
  class pl0_exec_scoreboard;
    logic [31:0]  regs [REG_COUNT];
    logic [31:0]  stk [STK_WORDS];
    int unsigned  pc, bp, sp;
    bit           hlt;
    exec_report_t pending[$];
    int           mismatches, checked, faults_seen, prints_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (stk[i]) stk[i] = '0;
      pc = 0; bp = 1; sp = 0; hlt = 0;
      mismatches = 0; checked = 0; faults_seen = 0; prints_seen = 0;
    endfunction

    function bit in_stack(longint a);
      return a >= 0 && a < STK_WORDS;
    endfunction

    function bit in_code(longint a);
      return a >= 0 && a < CODE_WORDS;
    endfunction

    function void note_instr(logic [79:0] d);
      logic [4:0]   op;
      logic [3:0]   r, la;
      longint       m, a, b, v, base, link, nsp, nbp, npc;
      logic [31:0]  rd;
      logic [2:0]   flt;
      bit           pv, ok;
      logic [31:0]  pval;
      exec_report_t rep;
      op = d[4:0]; r = d[8:5]; la = d[12:9];
      m = signed'(d[44:13]); rd = d[76:45];
      flt = FLT_OK; pv = 0; pval = '0; v = 0;
      if (!hlt) begin
        pc = (pc + 1) % CODE_WORDS;
        if (op >= OP_NEG) begin
          if (op == OP_NEG) regs[r] = -regs[r];
          else if (op == OP_ODD) regs[r] = regs[r] & 32'd1;
          else if (m < 0 || m >= REG_COUNT) flt = FLT_OP;
          else begin
            a = signed'(regs[la]);
            b = signed'(regs[m[3:0]]);
            case (op)
              OP_ADD: v = a + b;
              OP_SUB: v = a - b;
              OP_MUL: v = a * b;
              OP_DIV: if (b == 0) flt = FLT_DIV0; else v = a / b;
              OP_MOD: if (b == 0) flt = FLT_DIV0; else v = a % b;
              OP_EQL: v = longint'(a == b);
              OP_NEQ: v = longint'(a != b);
              OP_LSS: v = longint'(a < b);
              OP_LEQ: v = longint'(a <= b);
              OP_GTR: v = longint'(a > b);
              OP_GEQ: v = longint'(a >= b);
              default: flt = FLT_OP;
            endcase
            if (flt == FLT_OK) regs[r] = v[31:0];
          end
        end else begin
          case (op)
            OP_LIT: regs[r] = m[31:0];
            OP_RTN: begin
              nsp = longint'(bp) - 1;
              if (!in_stack(nsp) || !in_stack(nsp + 4)) flt = FLT_RANGE;
              else begin
                nbp = signed'(stk[nsp + 3]);
                npc = signed'(stk[nsp + 4]);
                if (!in_stack(nbp) || !in_code(npc)) flt = FLT_RANGE;
                else begin
                  sp = 32'(nsp); bp = 32'(nbp); pc = 32'(npc);
                end
              end
            end
            OP_LOD, OP_STO: begin
              // follow static links down from the current frame
              base = bp; ok = 1;
              for (int k = 0; k < la; k++) begin
                if (!in_stack(base + 1)) begin ok = 0; break; end
                link = signed'(stk[base + 1]);
                if (!in_stack(link)) begin ok = 0; break; end
                base = link;
              end
              if (!ok || !in_stack(base + m)) flt = FLT_RANGE;
              else if (op == OP_LOD) regs[r] = stk[base + m];
              else stk[base + m] = regs[r];
            end
            OP_CAL: flt = FLT_CAL;
            OP_INC: begin
              nsp = longint'(sp) + m;
              if (!in_stack(nsp)) flt = FLT_RANGE; else sp = 32'(nsp);
            end
            OP_JMP: if (!in_code(m)) flt = FLT_RANGE; else pc = 32'(m);
            OP_JPC: begin
              if (regs[r] == 0) begin
                if (!in_code(m)) flt = FLT_RANGE; else pc = 32'(m);
              end
            end
            OP_SIO: begin
              if (m == SIO_WRITE) begin pv = 1; pval = regs[r]; end
              else if (m == SIO_READ) stk[sp % STK_WORDS] = rd;
              else if (m == SIO_HALT) hlt = 1;
              else flt = FLT_OP;
            end
            default: flt = FLT_OP;
          endcase
        end
      end
      rep.next_pc = pc[8:0]; rep.frame_base = bp[9:0]; rep.stack_top = sp[9:0];
      rep.print_valid = pv; rep.print_value = pval; rep.halted = hlt; rep.fault = flt;
      pending.push_back(rep);
    endfunction

    function void check_report(logic [71:0] d);
      exec_report_t got, exp;
      got = d[65:0];
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output beat %h", d);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (exp.fault != FLT_OK) faults_seen++;
      if (exp.print_valid) prints_seen++;
      if (got.next_pc !== exp.next_pc || got.frame_base !== exp.frame_base ||
          got.stack_top !== exp.stack_top || got.print_valid !== exp.print_valid ||
          got.print_value !== exp.print_value || got.halted !== exp.halted ||
          got.fault !== exp.fault) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: beat %0d exp pc=%0d bp=%0d sp=%0d pv=%0b pval=%h h=%0b f=%0d",
                   checked, exp.next_pc, exp.frame_base, exp.stack_top, exp.print_valid,
                   exp.print_value, exp.halted, exp.fault,
                   " got pc=%0d bp=%0d sp=%0d pv=%0b pval=%h h=%0b f=%0d",
                   got.next_pc, got.frame_base, got.stack_top, got.print_valid,
                   got.print_value, got.halted, got.fault);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [79:0] s_tdata;   // func, reg_sel, level_or_src_a, operand_m, read_value, zero fill
  logic        m_tvalid, m_tready;
  logic [71:0] m_tdata;   // next_pc, frame_base_out, stack_top_out, print_valid,
                          // print_value, halted, fault, zero fill

  int unsigned idle_pct, stall_pct;
  int          items_sent;
  pl0_exec_scoreboard sb;

  pl0_register_machine_execute_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Random backpressure on the result side; stall rate set per phase.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Observe both handshakes at the edge where they complete.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_instr(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_report(m_tdata);
  end

  // Present one instruction beat, hold it until taken.
  task automatic send_instr(input logic [4:0] op, input logic [3:0] r, input logic [3:0] la,
                            input logic [31:0] m, input logic [31:0] rd);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b0, rd, m, la, r, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Interesting register values: extremes, small numbers, full random.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed instructions with random content, some noise.
  task automatic send_random();
    logic [4:0]  op;
    logic [3:0]  r, la;
    logic [31:0] m;
    int          pick;
    pick = $urandom_range(99);
    r = 4'($urandom_range(15)); la = 4'($urandom_range(15));
    m = $urandom_range(15);
    if (pick < 15) begin
      op = OP_LIT; m = pick_value();
    end else if (pick < 30) begin
      op = 5'($urandom_range(OP_GEQ, OP_NEG));
      if ($urandom_range(9) == 0) m = $urandom;
    end else if (pick < 48) begin
      op = $urandom_range(1) ? OP_STO : OP_LOD;
      la = ($urandom_range(3) == 0) ? 4'($urandom_range(3)) : 4'd0;
      m = $urandom_range(44) - 4;
    end else if (pick < 55) begin
      op = OP_INC; m = ($urandom_range(15) == 0) ? $urandom : $urandom_range(16) - 8;
    end else if (pick < 60) begin
      op = OP_JMP; m = ($urandom_range(7) == 0) ? $urandom : $urandom_range(CODE_WORDS - 1);
    end else if (pick < 66) begin
      op = OP_JPC; m = ($urandom_range(7) == 0) ? $urandom : $urandom_range(CODE_WORDS - 1);
    end else if (pick < 78) begin
      op = OP_SIO; m = $urandom_range(1) ? SIO_WRITE : SIO_READ;
    end else if (pick < 83) begin
      op = OP_RTN;
    end else if (pick < 86) begin
      op = OP_CAL;
    end else begin
      op = 5'($urandom_range(31)); m = $urandom;
      // halting would end the run early; keep it for the finale
      if (op == OP_SIO && m == SIO_HALT) m = 32'd4;
    end
    send_instr(op, r, la, m, $urandom);
  endtask

  initial begin
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];
    int          waited;
    idle_plan  = '{0, 71, 0, 9};
    stall_plan = '{0, 0, 71, 9};
    sb = new();
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
    idle_pct = 0; stall_pct = 0; items_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every opcode, the fault cases.
    send_instr(OP_LIT, 4'd0, 4'd0, 32'h7FFF_FFFF, 32'h0);
    send_instr(OP_LIT, 4'd1, 4'd0, 32'h8000_0000, 32'h0);
    send_instr(OP_LIT, 4'd2, 4'd0, 32'hFFFF_FFFF, 32'h0);
    send_instr(OP_ADD, 4'd4, 4'd0, 32'd0, 32'h0);        // wraps
    send_instr(OP_MUL, 4'd5, 4'd1, 32'd2, 32'h0);
    send_instr(OP_DIV, 4'd6, 4'd1, 32'd2, 32'h0);        // most negative / -1
    send_instr(OP_MOD, 4'd7, 4'd1, 32'd2, 32'h0);
    send_instr(OP_DIV, 4'd8, 4'd0, 32'd3, 32'h0);        // zero divisor
    send_instr(OP_MOD, 4'd8, 4'd1, 32'd15, 32'h0);
    send_instr(OP_SUB, 4'd9, 4'd1, 32'd0, 32'h0);
    send_instr(OP_ADD, 4'd9, 4'd0, 32'd16, 32'h0);       // bad second source
    send_instr(OP_ADD, 4'd9, 4'd0, 32'hFFFF_FFFF, 32'h0);
    send_instr(OP_NEG, 4'd1, 4'd0, 32'd0, 32'h0);
    send_instr(OP_ODD, 4'd2, 4'd0, 32'd0, 32'h0);
    for (int c = OP_EQL; c <= OP_GEQ; c++) send_instr(5'(c), 4'd10, 4'd0, 32'd1, 32'h0);
    send_instr(OP_STO, 4'd0, 4'd0, 32'd5, 32'h0);
    send_instr(OP_LOD, 4'd11, 4'd1, 32'd5, 32'h0);       // one static link
    send_instr(OP_LOD, 4'd11, 4'd0, 32'hFFFF_FFFE, 32'h0);
    send_instr(OP_INC, 4'd0, 4'd0, 32'd1023, 32'h0);
    send_instr(OP_INC, 4'd0, 4'd0, 32'd1, 32'h0);
    send_instr(OP_INC, 4'd0, 4'd0, 32'hFFFF_FC01, 32'h0);
    send_instr(OP_JMP, 4'd0, 4'd0, 32'd511, 32'h0);
    send_instr(OP_JMP, 4'd0, 4'd0, 32'd512, 32'h0);
    send_instr(OP_JPC, 4'd3, 4'd0, 32'd7, 32'h0);        // taken
    send_instr(OP_JPC, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'h0); // not taken
    send_instr(OP_SIO, 4'd1, 4'd0, SIO_WRITE, 32'h0);
    send_instr(OP_SIO, 4'd0, 4'd0, SIO_READ, 32'hA5A5_5A5A);
    send_instr(OP_SIO, 4'd0, 4'd0, 32'd0, 32'h0);
    send_instr(OP_CAL, 4'd0, 4'd0, 32'd0, 32'h0);
    send_instr(5'd0, 4'd0, 4'd0, 32'd0, 32'h0);
    send_instr(5'd31, 4'd0, 4'd0, 32'd0, 32'h0);
    send_instr(OP_RTN, 4'd0, 4'd0, 32'd0, 32'h0);
    send_instr(OP_RTN, 4'd0, 4'd0, 32'd0, 32'h0);        // frame below zero

    // Random program, one chunk per idling phase.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_plan[ph]; stall_pct = stall_plan[ph];
      repeat (RAND_ITEMS / 4) send_random();
    end

    // Halt, then confirm further instructions are ignored.
    idle_pct = 0; stall_pct = 9;
    send_instr(OP_SIO, 4'd0, 4'd0, SIO_HALT, 32'h0);
    repeat (3) send_random();
    s_tvalid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    $display("Ran %0d instructions, %0d state reports checked (%0d faults, %0d prints).",
             items_sent, sb.checked, sb.faults_seen, sb.prints_seen);
    $display("Idle/stall phases covered, halt and post-halt behavior exercised.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, reports missing: %0d", sb.mismatches, sb.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("Timeout waiting for the execution unit");
    $display("Test completed with failures");
    $finish;
  end

endmodule
